// ----- hw/rtl/mccd_pkg.sv -----
// shared types, constants and alert codes for the multi-channel closure detector
package mccd_pkg;

  // channel count and derived widths
  localparam int unsigned NumChannels = 8;
  localparam int unsigned ChIdxW      = $clog2(NumChannels);
  localparam int unsigned ChCntW      = $clog2(NumChannels + 1);
  localparam int unsigned StillW      = 4;

  // front queue depth
  localparam int unsigned QueueDepth  = 2;

  // configuration port
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned ThrW        = 15;

  // time constants in milliseconds, their width and the event counter ceiling
  localparam int unsigned   MsW           = 26;
  localparam logic [MsW-1:0] MsPerS       = 26'd1000;
  localparam logic [31:0]   HourMs        = 32'd3600000;
  localparam logic [31:0]   MultiWindowMs = 32'd60000;
  localparam logic [7:0]    EventCountMax = 8'hFF;

  typedef enum logic [1:0] {
    ALERT_CLEAR     = 2'd0,
    ALERT_EVENT     = 2'd1,
    ALERT_SUSTAINED = 2'd2,
    ALERT_MULTI     = 2'd3
  } alert_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAPE_THRESHOLD  = 3'd0,
    REG_MIN_EVENT_S     = 3'd1,
    REG_SUSTAINED_S     = 3'd2,
    REG_EVENTS_LIMIT    = 3'd3,
    REG_ACTIVE_CHANNELS = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [ThrW-1:0] gape_threshold;
    logic [15:0]     min_event_seconds;
    logic [15:0]     sustained_closure_seconds;
    logic [7:0]      events_per_hour_limit;
    logic [3:0]      active_channels;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        tick_time_ms;
    logic signed [15:0] gape_0;
    logic signed [15:0] gape_1;
    logic signed [15:0] gape_2;
    logic signed [15:0] gape_3;
    logic signed [15:0] gape_4;
    logic signed [15:0] gape_5;
    logic signed [15:0] gape_6;
    logic signed [15:0] gape_7;
  } in_word_t;

  typedef struct packed {
    alert_e      alert;
    logic [3:0]  channels_still_closed;
    alert_e      latched_alert;
    logic [31:0] latched_alert_time_ms;
  } out_word_t;

  // classified tick as it sits in the queue
  typedef struct packed {
    logic [31:0]            tick_time_ms;
    logic [NumChannels-1:0] valid;
    logic [NumChannels-1:0] closed;
  } item_t;

endpackage

// ----- hw/rtl/mccd_front.sv -----
// front end: accepts tick words, classifies each channel and queues the result
module mccd_front #(
  parameter int unsigned Depth = mccd_pkg::QueueDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mccd_pkg::ThrW-1:0]      threshold_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mccd_pkg::in_word_t             in_data_i,
  output logic                           item_valid_o,
  output mccd_pkg::item_t                item_o,
  input  logic                           item_pop_i
);
  import mccd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic signed [15:0] gape [NumChannels];
  item_t              cls;
  item_t              mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               push;

  // gather the channel samples
  assign gape[0] = in_data_i.gape_0;
  assign gape[1] = in_data_i.gape_1;
  assign gape[2] = in_data_i.gape_2;
  assign gape[3] = in_data_i.gape_3;
  assign gape[4] = in_data_i.gape_4;
  assign gape[5] = in_data_i.gape_5;
  assign gape[6] = in_data_i.gape_6;
  assign gape[7] = in_data_i.gape_7;

  // classify: negative sample is invalid, below threshold is closed
  always_comb begin
    cls.tick_time_ms = in_data_i.tick_time_ms;
    for (int i = 0; i < NumChannels; i++) begin
      cls.valid[i]  = !gape[i][15];
      cls.closed[i] = gape[i][ThrW-1:0] < threshold_i;
    end
  end

  // queue control
  assign in_stall_o   = (count_q == CntW'(Depth));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (item_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !item_pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && item_pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ----- hw/rtl/mccd_back.sv -----
// back end: walks the channels of one tick, keeps closure state, drives the result word
module mccd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mccd_pkg::cfg_t       cfg_i,
  input  logic                 item_valid_i,
  input  mccd_pkg::item_t      item_i,
  output logic                 item_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mccd_pkg::out_word_t  out_data_o
);
  import mccd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HOUR = 4'b0010,
    ST_CHAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  item_t              item_q, item_d;
  logic [ChCntW-1:0]  ch_q, ch_d;
  logic [ChCntW-1:0]  n_q, n_d;
  alert_e             alert_q, alert_d;
  logic [ChCntW-1:0]  still_q, still_d;
  logic [31:0]        earliest_q, earliest_d;
  logic               have_q, have_d;
  logic [31:0]        start_q [NumChannels];
  logic [31:0]        start_d [NumChannels];
  logic               prog_q [NumChannels];
  logic               prog_d [NumChannels];
  logic [7:0]         ev_q [NumChannels];
  logic [7:0]         ev_d [NumChannels];
  logic [31:0]        hour_q, hour_d;
  alert_e             held_q, held_d;
  logic [31:0]        held_time_q, held_time_d;
  out_word_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [MsW-1:0]     min_ms_q, min_ms_d;
  logic [MsW-1:0]     sus_ms_q, sus_ms_d;

  logic [ChIdxW-1:0]  idx;
  logic [31:0]        now;
  logic               ch_valid, ch_closed, ch_prog;
  logic [31:0]        ch_start, ch_dur;
  logic [7:0]         ch_ev, ev_inc, ev_new;
  logic               open_evt, sust_hit, limit_hit, multi_hit, out_free;
  alert_e             final_alert;

  // limits in milliseconds, one multiply each, registered
  assign min_ms_d = MsW'(cfg_i.min_event_seconds) * MsPerS;
  assign sus_ms_d = MsW'(cfg_i.sustained_closure_seconds) * MsPerS;

  // current channel view
  assign idx       = ch_q[ChIdxW-1:0];
  assign now       = item_q.tick_time_ms;
  assign ch_valid  = item_q.valid[idx];
  assign ch_closed = item_q.closed[idx];
  assign ch_prog   = prog_q[idx];
  assign ch_start  = start_q[idx];
  assign ch_ev     = ev_q[idx];
  assign ch_dur    = now - ch_start;
  assign ev_inc    = (ch_ev == EventCountMax) ? ch_ev : ch_ev + 8'd1;
  assign open_evt  = ch_valid && !ch_closed && ch_prog && (ch_dur >= 32'(min_ms_q));
  assign sust_hit  = ch_valid && ch_closed && ch_prog && (ch_dur >= 32'(sus_ms_q));
  assign ev_new    = open_evt ? ev_inc : ch_ev;
  assign limit_hit = ch_valid && (ev_new >= cfg_i.events_per_hour_limit);

  // end of tick decision
  assign multi_hit   = (still_q >= ChCntW'(2)) && have_q &&
                       ((now - earliest_q) < MultiWindowMs);
  assign final_alert = multi_hit ? ALERT_MULTI : alert_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    ch_d        = ch_q;
    n_d         = n_q;
    alert_d     = alert_q;
    still_d     = still_q;
    earliest_d  = earliest_q;
    have_d      = have_q;
    start_d     = start_q;
    prog_d      = prog_q;
    ev_d        = ev_q;
    hour_d      = hour_q;
    held_d      = held_q;
    held_time_d = held_time_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    item_pop_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          n_d        = (cfg_i.active_channels > 4'(NumChannels)) ?
                       ChCntW'(NumChannels) : ChCntW'(cfg_i.active_channels);
          state_d    = ST_HOUR;
        end
      end
      ST_HOUR: begin
        // hourly rollover clears every event counter at once
        if ((now - hour_q) >= HourMs) begin
          for (int i = 0; i < NumChannels; i++) begin
            ev_d[i] = '0;
          end
          hour_d = now;
        end
        alert_d    = ALERT_CLEAR;
        still_d    = '0;
        earliest_d = '0;
        have_d     = 1'b0;
        ch_d       = '0;
        state_d    = (n_q == '0) ? ST_DONE : ST_CHAN;
      end
      ST_CHAN: begin
        if (ch_valid) begin
          if (ch_closed && !ch_prog) begin
            start_d[idx] = now;
            prog_d[idx]  = 1'b1;
          end else if (!ch_closed && ch_prog) begin
            ev_d[idx]    = ev_new;
            prog_d[idx]  = 1'b0;
            start_d[idx] = '0;
          end else if (ch_closed && ch_prog) begin
            still_d = still_q + ChCntW'(1);
            if (!have_q || (ch_start < earliest_q)) begin
              earliest_d = ch_start;
              have_d     = 1'b1;
            end
          end
          // hourly limit and closure event take priority over a sustained closure within the channel
          if (limit_hit || open_evt) begin
            alert_d = ALERT_EVENT;
          end else if (sust_hit) begin
            alert_d = ALERT_SUSTAINED;
          end
        end
        ch_d = ch_q + ChCntW'(1);
        if (ch_d == n_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d                 = 1'b1;
          out_d.alert                 = final_alert;
          out_d.channels_still_closed = StillW'(still_q);
          if (final_alert != ALERT_CLEAR) begin
            held_d                      = final_alert;
            held_time_d                 = now;
            out_d.latched_alert         = final_alert;
            out_d.latched_alert_time_ms = now;
          end else begin
            out_d.latched_alert         = held_q;
            out_d.latched_alert_time_ms = held_time_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and closure state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      n_q         <= '0;
      alert_q     <= ALERT_CLEAR;
      still_q     <= '0;
      earliest_q  <= '0;
      have_q      <= 1'b0;
      hour_q      <= '0;
      held_q      <= ALERT_CLEAR;
      held_time_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumChannels; i++) begin
        start_q[i] <= '0;
        prog_q[i]  <= 1'b0;
        ev_q[i]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      n_q         <= n_d;
      alert_q     <= alert_d;
      still_q     <= still_d;
      earliest_q  <= earliest_d;
      have_q      <= have_d;
      hour_q      <= hour_d;
      held_q      <= held_d;
      held_time_q <= held_time_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < NumChannels; i++) begin
        start_q[i] <= start_d[i];
        prog_q[i]  <= prog_d[i];
        ev_q[i]    <= ev_d[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    out_q    <= out_d;
    min_ms_q <= min_ms_d;
    sus_ms_q <= sus_ms_d;
  end

endmodule

// ----- hw/rtl/multi_channel_closure_detector_top.sv -----
// top level of the multi-channel closure detector: config registers, front and back ends
//
//   port group   direction   handshake            word
//   in_*         input       in_valid/in_stall    tick time and eight gape samples
//   out_*        output      out_valid/out_stall  alert, still closed count, latched alert
//   cfg_*        input       cfg_we               register index and data
//
// a tick passes through the back end in steps: it is taken from the queue, the hourly
// rollover is applied, each of the N active channels (at most 8) goes in turn through
// the shared channel step, and the output register is loaded once the output is free.
// reset clears all closure state, counters and the queue at once; no clearing pass.
// the two-entry front queue keeps taking ticks while the back end works or the output
// stalls; once both entries are taken in_stall_o rises until the back end pops one.
module multi_channel_closure_detector_top #(
  parameter int unsigned FifoDepth = mccd_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mccd_pkg::in_word_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mccd_pkg::out_word_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [mccd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mccd_pkg::CfgDataW-1:0] cfg_data_i
);
  import mccd_pkg::*;

  cfg_t  cfg_q, cfg_d;
  item_t item;
  logic  item_valid;
  logic  item_pop;

  // configuration register write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_GAPE_THRESHOLD:  cfg_d.gape_threshold            = cfg_data_i[ThrW-1:0];
        REG_MIN_EVENT_S:     cfg_d.min_event_seconds         = cfg_data_i;
        REG_SUSTAINED_S:     cfg_d.sustained_closure_seconds = cfg_data_i;
        REG_EVENTS_LIMIT:    cfg_d.events_per_hour_limit     = cfg_data_i[7:0];
        REG_ACTIVE_CHANNELS: cfg_d.active_channels           = cfg_data_i[3:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gape_threshold            <= 15'd500;
      cfg_q.min_event_seconds         <= 16'd30;
      cfg_q.sustained_closure_seconds <= 16'd600;
      cfg_q.events_per_hour_limit     <= 8'd5;
      cfg_q.active_channels           <= 4'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify and queue
  mccd_front #(
    .Depth (FifoDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .threshold_i  (cfg_q.gape_threshold),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // channel walk and result word
  mccd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTHESIS
  // a fresh alert is always the latched one
  a_latch_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.alert != ALERT_CLEAR) |->
      out_data_o.latched_alert == out_data_o.alert)
    else $error("latched alert differs from fresh alert");

  // multi-channel alert needs two channels still closed
  a_multi_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.alert == ALERT_MULTI) |->
      out_data_o.channels_still_closed >= StillW'(2))
    else $error("multi-channel alert with fewer than two closed channels");

  // still closed count bounded by channel count
  a_still_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.channels_still_closed <= StillW'(NumChannels))
    else $error("still closed count above channel count");
`endif

endmodule

// ----- tb/sv/multi_channel_closure_detector_top_tb.sv -----
// self-checking testbench for the multi-channel closure detector top level
module multi_channel_closure_detector_top_tb;
  import mccd_pkg::*;

  // block ports
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_word_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // one row of the directed stimulus table
  typedef struct packed {
    in_word_t  tick;
    logic      typed;
    out_word_t want;
  } tick_row_t;

  // register copies held by the predictor
  logic [ThrW-1:0] thr_q;
  logic [15:0]     min_event_s_q;
  logic [15:0]     sustained_s_q;
  logic [7:0]      event_limit_q;
  logic [3:0]      active_q;

  // predicted per-channel and global state
  logic [31:0] closure_start [NumChannels];
  bit          closing       [NumChannels];
  logic [7:0]  hourly_events [NumChannels];
  logic [31:0] hour_start;
  alert_e      held_alert;
  logic [31:0] held_time;

  // stimulus and checking bookkeeping
  out_word_t   expected_results [$];
  tick_row_t   tick_table [$];
  bit          want_closed [NumChannels];
  logic [31:0] tick_now;
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned ticks_sent = 0;
  int unsigned settings_used = 1;
  int unsigned alerts_seen [4] = '{0, 0, 0, 0};

  multi_channel_closure_detector_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock, period 10
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // gape of channel i sits 16 bits below the previous one, channel 0 on top
  function automatic in_word_t set_gape(in_word_t w, int i, logic [15:0] g);
    w[127 - 16*i -: 16] = g;
    return w;
  endfunction

  function automatic in_word_t uniform_tick(logic [31:0] t, logic [15:0] g);
    in_word_t w;
    w = '0;
    w.tick_time_ms = t;
    for (int i = 0; i < NumChannels; i++) w = set_gape(w, i, g);
    return w;
  endfunction

  function automatic void add_row(in_word_t t, logic typed, out_word_t want);
    tick_row_t row;
    row.tick  = t;
    row.typed = typed;
    row.want  = want;
    tick_table.push_back(row);
  endfunction

  // closure tracking for one tick: updates the predicted state, returns the word
  function automatic out_word_t predict_closure_alert(in_word_t w);
    logic [127:0] gapes;
    logic [15:0]  g;
    logic [31:0]  now, dur, earliest, min_ms, sus_ms;
    bit           have_earliest, shut;
    int unsigned  n;
    alert_e       alert;
    logic [3:0]   still;
    out_word_t    r;
    gapes         = w[127:0];
    now           = w.tick_time_ms;
    alert         = ALERT_CLEAR;
    still         = '0;
    earliest      = '0;
    have_earliest = 1'b0;
    min_ms        = 32'(min_event_s_q) * 32'd1000;
    sus_ms        = 32'(sustained_s_q) * 32'd1000;
    n             = (active_q > 4'(NumChannels)) ? NumChannels : 32'(active_q);
    // hourly rollover clears the event counts first
    if (now - hour_start >= HourMs) begin
      for (int i = 0; i < NumChannels; i++) hourly_events[i] = '0;
      hour_start = now;
    end
    // channels lowest first, a negative gape skips the channel
    for (int i = 0; i < n; i++) begin
      g = gapes[127 - 16*i -: 16];
      if (!g[15]) begin
        shut = g[14:0] < thr_q;
        if (shut && !closing[i]) begin
          closure_start[i] = now;
          closing[i]       = 1'b1;
        end else if (!shut && closing[i]) begin
          dur = now - closure_start[i];
          if (dur >= min_ms) begin
            if (hourly_events[i] != EventCountMax) hourly_events[i]++;
            alert = ALERT_EVENT;
          end
          closing[i]       = 1'b0;
          closure_start[i] = '0;
        end else if (shut && closing[i]) begin
          dur = now - closure_start[i];
          if (dur >= sus_ms) alert = ALERT_SUSTAINED;
          still++;
          if (!have_earliest || closure_start[i] < earliest) begin
            earliest      = closure_start[i];
            have_earliest = 1'b1;
          end
        end
        if (hourly_events[i] >= event_limit_q) alert = ALERT_EVENT;
      end
    end
    // several channels shut within the last minute override everything
    if (still >= 4'd2 && have_earliest && now - earliest < MultiWindowMs) alert = ALERT_MULTI;
    if (alert != ALERT_CLEAR) begin
      held_alert = alert;
      held_time  = now;
    end
    r.alert                 = alert;
    r.channels_still_closed = still;
    r.latched_alert         = held_alert;
    r.latched_alert_time_ms = held_time;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic check_result(out_word_t got);
    out_word_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("word %0d arrived with no tick waiting", results_checked));
    end else begin
      want = expected_results.pop_front();
      if (got.alert !== want.alert)
        report_mismatch($sformatf("word %0d alert %0d, expected %0d",
                                  results_checked, got.alert, want.alert));
      if (got.channels_still_closed !== want.channels_still_closed)
        report_mismatch($sformatf("word %0d still closed %0d, expected %0d", results_checked,
                                  got.channels_still_closed, want.channels_still_closed));
      if (got.latched_alert !== want.latched_alert)
        report_mismatch($sformatf("word %0d latched alert %0d, expected %0d",
                                  results_checked, got.latched_alert, want.latched_alert));
      if (got.latched_alert_time_ms !== want.latched_alert_time_ms)
        report_mismatch($sformatf("word %0d latched time %0h, expected %0h", results_checked,
                                  got.latched_alert_time_ms, want.latched_alert_time_ms));
    end
    results_checked++;
    alerts_seen[got.alert]++;
  endtask

  // output side: check accepted words, then draw the next stall burst
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_data_o);
    if (stall_left != 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
    out_stall_i <= idle_on && (stall_left != 0);
  end

  // input side: optional idle burst, then hold the word until accepted
  task automatic send_tick(in_word_t w, logic typed, out_word_t want);
    out_word_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_closure_alert(w);
    expected_results.push_back(typed ? want : predicted);
    ticks_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      REG_GAPE_THRESHOLD:  thr_q         = data[ThrW-1:0];
      REG_MIN_EVENT_S:     min_event_s_q = data;
      REG_SUSTAINED_S:     sustained_s_q = data;
      REG_EVENTS_LIMIT:    event_limit_q = data[7:0];
      REG_ACTIVE_CHANNELS: active_q      = data[3:0];
      default: ;
    endcase
  endtask

  // all five registers, then a write to an unmapped index that must be ignored
  task automatic apply_setting(logic [15:0] thr, logic [15:0] min_s, logic [15:0] sus_s,
                               logic [15:0] limit, logic [15:0] active);
    write_reg(REG_GAPE_THRESHOLD, thr);
    write_reg(REG_MIN_EVENT_S, min_s);
    write_reg(REG_SUSTAINED_S, sus_s);
    write_reg(REG_EVENTS_LIMIT, limit);
    write_reg(REG_ACTIVE_CHANNELS, active);
    write_reg(CfgIdxW'(REG_ACTIVE_CHANNELS + 1 + $urandom_range(0, 2)),
              CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // channels mostly hold their open or shut state, with some invalid and raw samples
  task automatic run_random_ticks(int unsigned count);
    in_word_t    w;
    logic [15:0] g;
    logic [31:0] rnd;
    int unsigned r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) tick_now = $urandom;
      else if (r < 8) tick_now += $urandom_range(3_000_000, 70_000_000);
      else if (r < 30) tick_now += $urandom_range(20_000, 70_000);
      else tick_now += $urandom_range(0, 6_000);
      w = uniform_tick(tick_now, '0);
      for (int i = 0; i < NumChannels; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          rnd = $urandom;
          g   = {1'b1, rnd[14:0]};
        end else if (r < 12) begin
          rnd = $urandom;
          g   = rnd[15:0];
        end else begin
          if ($urandom_range(0, 7) == 0) want_closed[i] = !want_closed[i];
          if (want_closed[i] && thr_q != 0) rnd = $urandom_range(0, 32'(thr_q) - 32'd1);
          else rnd = $urandom_range(32'(thr_q), 32767);
          g = {1'b0, rnd[14:0]};
        end
        w = set_gape(w, i, g);
      end
      send_tick(w, 1'b0, '0);
    end
  endtask

  // main sequence
  initial begin
    // predictor starts from the reset state
    thr_q         = 15'd500;
    min_event_s_q = 16'd30;
    sustained_s_q = 16'd600;
    event_limit_q = 8'd5;
    active_q      = 4'd8;
    for (int i = 0; i < NumChannels; i++) begin
      closure_start[i] = '0;
      closing[i]       = 1'b0;
      hourly_events[i] = '0;
      want_closed[i]   = 1'b0;
    end
    hour_start = '0;
    held_alert = ALERT_CLEAR;
    held_time  = '0;

    // directed table, reset register values
    add_row(uniform_tick(32'd0, 16'sd32767), 1'b1, '0);
    add_row(uniform_tick(32'd1, -16'sd32768), 1'b1, '0);
    // rollover at the top of the time range; channel 7 shuts at start time all ones
    add_row(set_gape(uniform_tick(32'hFFFF_FFFF, -16'sd1), 7, 16'd0), 1'b1, '0);
    add_row(uniform_tick(32'd1000, 16'd0), 1'b1, {ALERT_CLEAR, 4'd1, ALERT_CLEAR, 32'd0});
    add_row(uniform_tick(32'd2000, 16'd0), 1'b1, {ALERT_MULTI, 4'd8, ALERT_MULTI, 32'd2000});
    // channel 0 opens after the minimum, others stay shut
    add_row(set_gape(uniform_tick(32'd32000, 16'd0), 0, 16'd600), 1'b0, '0);
    // sustained closure just under threshold, channel 0 invalid
    add_row(set_gape(uniform_tick(32'd700000, 16'd499), 0, -16'sd5), 1'b0, '0);
    // gape equal to threshold counts as open
    add_row(uniform_tick(32'd700100, 16'd500), 1'b0, '0);
    // channel 2 alone cycles until its hourly count reaches the limit
    for (int k = 0; k < 4; k++) begin
      add_row(set_gape(uniform_tick(32'd800000 + 100000 * k, -16'sd1), 2, 16'd0), 1'b0, '0);
      add_row(set_gape(uniform_tick(32'd830000 + 100000 * k, -16'sd1), 2, 16'd12345),
              1'b0, '0);
    end
    add_row(uniform_tick(32'd1200000, 16'd1000), 1'b0, '0);
    add_row(uniform_tick(32'd3601000, 16'd1000), 1'b0, '0);
    // durations across the time wrap
    add_row(set_gape(uniform_tick(32'hFFFF_F000, 16'd0), 7, 16'h7FFF), 1'b0, '0);
    add_row(uniform_tick(32'h0000_0800, 16'd0), 1'b0, '0);
    add_row(set_gape(uniform_tick(32'h0000_2000, 16'h5555), 3, 16'h2AAA), 1'b0, '0);
    tick_now = 32'h0000_2000;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tick_table[k]) send_tick(tick_table[k].tick, tick_table[k].typed, tick_table[k].want);

    // random phases, registers changed only with nothing in flight
    for (int p = 0; p < 6; p++) begin
      in_valid_i <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk_i);
      case (p)
        0: apply_setting(16'hFFFF, 16'd0, 16'd0, 16'hFF00, 16'd8);
        1: apply_setting(16'd0, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'h000F);
        2: apply_setting(16'd2000, 16'd1, 16'd60, 16'd2, 16'd3);
        4: apply_setting(16'd500, 16'd5, 16'd120, 16'd4, 16'd8);
        default: apply_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 15)));
      endcase
      // no idling at all in the closing phase
      idle_on = (p != 5) && ($urandom_range(0, 3) != 0);
      run_random_ticks(172);
    end

    // drain and let any stray word show up
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    $display("closure detector: %0d ticks under %0d register settings, %0d words checked",
             ticks_sent, settings_used, results_checked);
    $display("alerts seen: closure event %0d, sustained %0d, multi-channel %0d",
             alerts_seen[ALERT_EVENT], alerts_seen[ALERT_SUSTAINED], alerts_seen[ALERT_MULTI]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- multi_channel_closure_detector_top.f -----
hw/rtl/mccd_pkg.sv
hw/rtl/mccd_front.sv
hw/rtl/mccd_back.sv
hw/rtl/multi_channel_closure_detector_top.sv
tb/sv/multi_channel_closure_detector_top_tb.sv
